### rtl/poc_pkg.sv
// Shared types and constants for the pattern occurrence counter.
`timescale 1ns / 1ps
`default_nettype none
package poc_pkg;

	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 64;
	localparam int PAT_WORDS  = 4;
	localparam int PAT_BYTES  = 32;
	localparam int LEN_W      = 6;
	localparam int COUNT_W    = 32;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// Register index codes, taken from paddr[5:3]
	localparam logic [2:0] REG_PATTERN_0 = 3'd0;
	localparam logic [2:0] REG_PATTERN_1 = 3'd1;
	localparam logic [2:0] REG_PATTERN_2 = 3'd2;
	localparam logic [2:0] REG_PATTERN_3 = 3'd3;
	localparam logic [2:0] REG_LENGTH    = 3'd4;

	localparam logic [LEN_W-1:0] LENGTH_RESET = 6'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_text;
	} text_t;

	typedef struct packed {
		logic               match_here;
		logic [COUNT_W-1:0] match_total;
		logic [COUNT_W-1:0] line_total;
	} result_t;

	typedef struct packed {
		logic [PAT_WORDS-1:0][DATA_W-1:0] pattern_word;
		logic [LEN_W-1:0]                 pattern_length;
	} cfg_t;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

endpackage
`default_nettype wire

### rtl/pattern_occurrence_counter.sv
// Top level: input register, scan logic, result register and APB port.
`timescale 1ns / 1ps
`default_nettype none
// Counts occurrences (overlaps included) of a 1 to MAX_PATTERN byte pattern
// and newline bytes in a byte stream. One byte is taken per clock while
// text_stall is low; each byte gives one result, passing from the input
// register through the window compare into the result register. The result
// register is refilled in the cycle it is taken, so the rate stays one byte
// per cycle while result_stall is low. Program the pattern words at byte
// addresses 0x00..0x18 and the length at 0x20 while the stream is idle;
// start_of_text clears history and both counters before its byte.
module pattern_occurrence_counter #(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [poc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [poc_pkg::DATA_W-1:0] pwdata,
	output      logic [poc_pkg::DATA_W-1:0] prdata,
	output      logic                       pready,
	input  wire logic                       text_valid,
	output      logic                       text_stall,
	input  wire poc_pkg::text_t             text_data,
	output      logic                       result_valid,
	input  wire logic                       result_stall,
	output      poc_pkg::result_t           result_data
);
	import poc_pkg::*;

	cfg_t    cfg;
	text_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    take;
	result_t res;
	result_t res_q;
	logic    res_valid_q;

	poc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	poc_scan #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.res     (res)
	);

	// Move the staged byte on when the result register is free or drains now
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign text_stall = valid_s1 && !advance;
	assign take       = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
			if (advance)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= text_data;
		if (advance)
			res_q <= res;
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> (valid_s1 && res_valid_q && result_stall))
		else $error("input stalled without a blocked result");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("result appeared with no staged byte");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("stalled result dropped");

endmodule
`default_nettype wire

### rtl/poc_cfg.sv
// APB register file holding the pattern words and the pattern length.
`timescale 1ns / 1ps
`default_nettype none
module poc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [poc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [poc_pkg::DATA_W-1:0] pwdata,
	output      logic [poc_pkg::DATA_W-1:0] prdata,
	output      logic                       pready,
	output      poc_pkg::cfg_t              cfg
);
	import poc_pkg::*;

	logic [PAT_WORDS-1:0][DATA_W-1:0] pattern_q;
	logic [LEN_W-1:0]                 length_q;
	logic [2:0]                       reg_idx;
	logic                             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LENGTH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PATTERN_0: pattern_q[0] <= pwdata;
				REG_PATTERN_1: pattern_q[1] <= pwdata;
				REG_PATTERN_2: pattern_q[2] <= pwdata;
				REG_PATTERN_3: pattern_q[3] <= pwdata;
				REG_LENGTH:    length_q     <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PATTERN_0: prdata = pattern_q[0];
			REG_PATTERN_1: prdata = pattern_q[1];
			REG_PATTERN_2: prdata = pattern_q[2];
			REG_PATTERN_3: prdata = pattern_q[3];
			REG_LENGTH:    prdata = {{(DATA_W-LEN_W){1'b0}}, length_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.pattern_word   = pattern_q;
	assign cfg.pattern_length = length_q;

endmodule
`default_nettype wire

### rtl/poc_scan.sv
// Byte window, parallel pattern compare and the two saturating counters.
`timescale 1ns / 1ps
`default_nettype none
module poc_scan #(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire poc_pkg::cfg_t   cfg,
	input  wire poc_pkg::text_t  item,
	input  wire logic            advance,
	output      poc_pkg::result_t res
);
	import poc_pkg::*;

	localparam int WIN_D  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_PATTERN);

	logic [WIN_D-1:0][7:0] win_q;
	logic [FILL_W-1:0]     fill_q;
	logic [COUNT_W-1:0]    match_q;
	logic [COUNT_W-1:0]    line_q;

	pat_bytes_t            pat;
	logic [LEN_W-1:0]      len;
	logic [FILL_W-1:0]     fill_eff;
	logic [COUNT_W-1:0]    match_eff;
	logic [COUNT_W-1:0]    line_eff;
	logic [MAX_PATTERN-1:0] pos_ok;
	logic                  hit;
	logic                  is_newline;
	logic [COUNT_W-1:0]    match_nxt;
	logic [COUNT_W-1:0]    line_nxt;

	assign pat = pat_bytes_t'(cfg.pattern_word);

	// Clamp the length into 1..MAX_PATTERN
	always_comb begin
		if (cfg.pattern_length == '0)
			len = LEN_W'(1);
		else if (cfg.pattern_length > LEN_MAX)
			len = LEN_MAX;
		else
			len = cfg.pattern_length;
	end

	// Start of text drops history and counts before this byte
	assign fill_eff  = item.start_of_text ? '0 : fill_q;
	assign match_eff = item.start_of_text ? '0 : match_q;
	assign line_eff  = item.start_of_text ? '0 : line_q;

	// Position k back from the current byte must equal pattern byte len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
		logic [LEN_W-1:0] pidx;
		logic [7:0]       hist;
		assign pidx = len - LEN_W'(1) - LEN_W'(k);
		if (k == 0) begin : g_cur
			assign hist = item.data_byte;
		end else begin : g_win
			assign hist = win_q[k-1];
		end
		assign pos_ok[k] = (LEN_W'(k) >= len) || (hist == pat[pidx[4:0]]);
	end

	assign hit = ((LEN_W'(fill_eff) + LEN_W'(1)) >= len) && (&pos_ok);
	assign is_newline = (item.data_byte == NEWLINE_BYTE);

	assign match_nxt = (hit && (match_eff != '1)) ? match_eff + COUNT_W'(1) : match_eff;
	assign line_nxt  = (is_newline && (line_eff != '1)) ? line_eff + COUNT_W'(1) : line_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			match_q <= '0;
			line_q  <= '0;
		end else if (advance) begin
			fill_q  <= (fill_eff < FILL_MAX) ? fill_eff + FILL_W'(1) : fill_eff;
			match_q <= match_nxt;
			line_q  <= line_nxt;
		end
	end

	// History bytes; entries beyond the fill count never affect a match
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q[0] <= item.data_byte;
			for (int i = 1; i < WIN_D; i++)
				win_q[i] <= win_q[i-1];
		end
	end

	assign res.match_here  = hit;
	assign res.match_total = match_nxt;
	assign res.line_total  = line_nxt;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("window fill beyond window depth");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && hit) |=> (match_q != '0))
		else $error("match transferred but counter still zero");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item.start_of_text && (fill_q < FILL_MAX)) |=>
		(fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("window fill did not advance");

endmodule
`default_nettype wire
